### design/kwm_pkg.sv
// Shared widths, request and status codes for the k-way merge heap.
package kwm_pkg;

  localparam int KEY_W        = 32;
  localparam int RUN_W        = 9;
  localparam int ENTRY_W      = KEY_W + RUN_W;
  localparam int DEF_MAX_RUNS = 512;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

endpackage

### design/kway_merge_min_heap.sv
// Binary min-heap priority queue for a k-way merge, held in one synchronous memory.
//
// Start a beat with start while busy is low: req_type picks insert (key_in, run_in)
// or pop. Exactly one result follows, shown for one cycle with done high: key_out
// and run_out carry the popped entry (zero otherwise), status flags a pop on an
// empty queue or an insert on a full one, now_empty tells whether the queue is
// empty afterwards. The receiver cannot hold a result off; done and the result
// fields must be sampled in that cycle. Entries order by key, then by lower run
// index. An error, or an insert into an empty queue, answers straight from idle;
// otherwise an insert sifts up level by level through S_UP (and S_FILL once it
// reaches the root); a pop reads the root in S_POP_LD, then sifts down in S_DOWN.
// The heap memory has one write port and two read ports and is touched once per
// level. A new beat may start in the done cycle.
module kway_merge_min_heap #(
  parameter int MAX_RUNS = kwm_pkg::DEF_MAX_RUNS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type,
  input  logic [kwm_pkg::KEY_W-1:0] key_in,
  input  logic [kwm_pkg::RUN_W-1:0] run_in,
  output logic                     done,
  output logic [kwm_pkg::KEY_W-1:0] key_out,
  output logic [kwm_pkg::RUN_W-1:0] run_out,
  output logic [1:0]               status,
  output logic                     now_empty
);

  localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int XW = AW + 2;
  localparam int EW = kwm_pkg::ENTRY_W;
  localparam int RW = kwm_pkg::RUN_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_RUNS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UP     = 5'b00010,
    S_FILL   = 5'b00100,
    S_POP_LD = 5'b01000,
    S_DOWN   = 5'b10000
  } state_t;

  state_t          state;
  logic [CW-1:0]   cnt;
  logic [AW-1:0]   pos;
  logic [EW-1:0]   item;

  // heap storage and its ports
  logic [EW-1:0]   heap_mem [MAX_RUNS];
  logic [EW-1:0]   rd_a;
  logic [EW-1:0]   rd_b;
  logic [AW-1:0]   ra;
  logic [AW-1:0]   rb;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [EW-1:0]   wdata;

  // sift decisions
  logic [CW-1:0]   cnt_m1;
  logic [AW-1:0]   ins_par;
  logic [AW-1:0]   par_pos;
  logic [AW-1:0]   par_par;
  logic            up_move;
  logic [XW-1:0]   cnt_ext;
  logic [XW-1:0]   left;
  logic [XW-1:0]   right;
  logic            dn_move;
  logic [EW-1:0]   best_val;
  logic [AW-1:0]   dn_addr;
  logic [AW-1:0]   base;
  logic [XW-1:0]   ch_l;
  logic [XW-1:0]   ch_r;
  logic            accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // work out parent and child positions and the compare results
  always_comb begin
    cnt_m1  = cnt - CW'(1);
    ins_par = AW'(cnt_m1 >> 1);
    par_pos = (pos - AW'(1)) >> 1;
    par_par = (par_pos - AW'(1)) >> 1;
    up_move = (item < rd_a);

    cnt_ext = XW'(cnt);
    left    = {1'b0, pos, 1'b1};
    right   = left + XW'(1);
    dn_move  = 1'b0;
    best_val = item;
    dn_addr  = pos;
    if ((left < cnt_ext) && (rd_a < item)) begin
      dn_move  = 1'b1;
      best_val = rd_a;
      dn_addr  = left[AW-1:0];
    end
    if ((right < cnt_ext) && (rd_b < best_val)) begin
      dn_move  = 1'b1;
      best_val = rd_b;
      dn_addr  = right[AW-1:0];
    end

    base = (state == S_DOWN) ? dn_addr : '0;
    ch_l = {1'b0, base, 1'b1};
    ch_r = ch_l + XW'(1);
  end

  // choose memory addresses and write data
  always_comb begin
    ra    = '0;
    rb    = '0;
    we    = 1'b0;
    waddr = pos;
    wdata = item;
    unique case (state)
      S_IDLE: begin
        ra    = (req_type == kwm_pkg::REQ_POP) ? '0 : ins_par;
        rb    = cnt_m1[AW-1:0];
        we    = accept && (req_type == kwm_pkg::REQ_INSERT) && (cnt == '0);
        waddr = '0;
        wdata = {key_in, run_in};
      end
      S_UP: begin
        ra    = par_par;
        we    = 1'b1;
        wdata = up_move ? rd_a : item;
      end
      S_FILL: begin
        we = 1'b1;
      end
      S_POP_LD: begin
        ra = ch_l[AW-1:0];
        rb = ch_r[AW-1:0];
      end
      S_DOWN: begin
        ra    = ch_l[AW-1:0];
        rb    = ch_r[AW-1:0];
        we    = 1'b1;
        wdata = dn_move ? best_val : item;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rd_a <= heap_mem[ra];
    rd_b <= heap_mem[rb];
  end

  // sequence each beat through the heap levels
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key_out <= '0;
            run_out <= '0;
            if (req_type == kwm_pkg::REQ_INSERT) begin
              if (cnt == FULL_CNT) begin
                status    <= kwm_pkg::STAT_FULL;
                now_empty <= 1'b0;
                done      <= 1'b1;
              end else begin
                status <= kwm_pkg::STAT_OK;
                item   <= {key_in, run_in};
                pos    <= cnt[AW-1:0];
                cnt    <= cnt + CW'(1);
                if (cnt == '0) begin
                  now_empty <= 1'b0;
                  done      <= 1'b1;
                end else begin
                  state <= S_UP;
                end
              end
            end else begin
              if (cnt == '0) begin
                status    <= kwm_pkg::STAT_EMPTY;
                now_empty <= 1'b1;
                done      <= 1'b1;
              end else begin
                status <= kwm_pkg::STAT_OK;
                state  <= S_POP_LD;
              end
            end
          end
        end
        S_UP: begin
          if (up_move) begin
            pos <= par_pos;
            if (par_pos == '0) begin
              state <= S_FILL;
            end
          end else begin
            now_empty <= 1'b0;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_FILL: begin
          now_empty <= 1'b0;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_POP_LD: begin
          key_out <= rd_a[EW-1:RW];
          run_out <= rd_a[RW-1:0];
          item    <= rd_b;
          cnt     <= cnt_m1;
          pos     <= '0;
          if (cnt_m1 == '0) begin
            now_empty <= 1'b1;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_DOWN;
          end
        end
        S_DOWN: begin
          if (dn_move) begin
            pos <= dn_addr;
          end else begin
            now_empty <= 1'b0;
            done      <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/kwm_checker.sv
// Port-level checks for the k-way merge heap, bound to the top level.
module kwm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic [kwm_pkg::KEY_W-1:0] key_out,
  input logic [kwm_pkg::RUN_W-1:0] run_out,
  input logic [1:0]                status,
  input logic                      now_empty
);

  // an accepted beat either keeps the block busy or answers next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat neither busy nor answered");

  // a result closes the work on its beat
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  // error results carry no entry
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != kwm_pkg::STAT_OK)) |-> ((key_out == '0) && (run_out == '0)))
    else $error("error result carries an entry");

  // pop on empty leaves the queue empty
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (done && (status == kwm_pkg::STAT_EMPTY)) |-> now_empty)
    else $error("empty pop without empty flag");

  // full error can only come from a non-empty queue
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (done && (status == kwm_pkg::STAT_FULL)) |-> !now_empty)
    else $error("full error with empty flag");

endmodule

bind kway_merge_min_heap kwm_checker u_kwm_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .key_out   (key_out),
  .run_out   (run_out),
  .status    (status),
  .now_empty (now_empty)
);
